// ===== hw/rtl/gdt_pkg.sv =====
// Shared definitions for the GUID text parser: group layout tables, the hex
// digit decoder and the result status codes.
// No dependencies.
package gdt_pkg;

	localparam int unsigned GROUP_COUNT = 5;
	localparam int unsigned BYTE_COUNT  = 16;
	localparam logic [2:0]  LAST_GROUP  = 3'(GROUP_COUNT - 1);

	localparam logic [15:0] CHAR_HYPHEN = 16'h002D;
	localparam logic [15:0] CHAR_NUL    = 16'h0000;

	localparam logic [3:0] NIBBLE_LETTER_BASE = 4'hA;
	localparam logic [7:0] HIGH_NIBBLE_MASK   = 8'hF0;

	typedef enum logic [1:0] {
		STATUS_OK          = 2'd0,
		STATUS_BAD_DIGIT   = 2'd1,
		STATUS_MISSING_SEP = 2'd2
	} status_t;

	typedef logic [7:0] byte_t;

	// Number of hex digits in each group.
	function automatic logic [4:0] group_digits(input logic [2:0] g);
		logic [4:0] r;
		case (g)
			3'd0:    r = 5'd8;
			3'd1:    r = 5'd4;
			3'd2:    r = 5'd4;
			3'd3:    r = 5'd4;
			default: r = 5'd12;
		endcase
		return r;
	endfunction

	// Index of the first byte that each group fills.
	function automatic logic [3:0] group_first_byte(input logic [2:0] g);
		logic [3:0] r;
		case (g)
			3'd0:    r = 4'd0;
			3'd1:    r = 4'd4;
			3'd2:    r = 4'd6;
			3'd3:    r = 4'd8;
			default: r = 4'd10;
		endcase
		return r;
	endfunction

	// Bit 4 is set when the character is not a hex digit; bits 3:0 hold the value.
	function automatic logic [4:0] hex_value(input logic [15:0] c);
		logic [4:0] r;
		if (c >= 16'h0061 && c <= 16'h0066) begin
			r = {1'b0, c[3:0] - 4'h1 + NIBBLE_LETTER_BASE};
		end else if (c >= 16'h0041 && c <= 16'h0046) begin
			r = {1'b0, c[3:0] - 4'h1 + NIBBLE_LETTER_BASE};
		end else if (c >= 16'h0030 && c <= 16'h0039) begin
			r = {1'b0, c[3:0]};
		end else begin
			r = 5'h10;
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/guid_text_to_bytes.sv =====
// Top level of the GUID text parser: turns a stream of UTF-16 characters into
// the sixteen bytes of a registry-format GUID. Depends on gdt_pkg.
//
// Usage:
//   The input channel (in_valid, in_stall, code_unit, starts_string) carries
//   one UTF-16 character per request. A request with starts_string set opens
//   a new string and abandons any parse in progress. Characters arriving
//   while no string is open are consumed and dropped.
//   The output channel (out_valid, out_stall, guid_first_half,
//   guid_second_half, status) carries one request per finished string: the
//   bytes in text order (byte 0 in the top bits of guid_first_half) and a
//   status of ok, a group cut short by a non-hex digit, or missing hyphen.
// Timing:
//   An accepted character waits in the input register until it fires; at
//   that edge the parse state is updated and a result it completes is
//   loaded into the output register at the same edge.
//   One character is taken every cycle while no result is stalled; the
//   parse state update is the only loop in the design.
// Reset and stall:
//   After reset no string is open and the output register is empty.
//   While the receiver stalls a pending result, the character in the input
//   register waits and in_stall rises; the input side moves again in the same
//   cycle the result is taken.
module guid_text_to_bytes (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] code_unit,
	input  logic        starts_string,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] guid_first_half,
	output logic [63:0] guid_second_half,
	output logic [1:0]  status
);

	// Input register stage.
	logic        valid_s1;
	logic [15:0] code_s1;
	logic        start_s1;

	// Parse state.
	gdt_pkg::byte_t bytes_q [gdt_pkg::BYTE_COUNT];
	logic [2:0]     group_q;
	logic [3:0]     digits_q;
	logic           decoding_q;
	logic           bad_q;
	logic           finished_q;

	// Output register.
	logic        out_valid_q;
	logic [63:0] first_q;
	logic [63:0] second_q;
	logic [1:0]  status_q;

	// Next-state values.
	gdt_pkg::byte_t bytes_n [gdt_pkg::BYTE_COUNT];
	logic [2:0]     group_n;
	logic [3:0]     digits_n;
	logic           decoding_n;
	logic           bad_n;
	logic           finished_n;
	logic           emit;
	gdt_pkg::status_t emit_status;
	logic [63:0]    first_n;
	logic [63:0]    second_n;

	logic in_accept;
	logic slot_free;
	logic fire;

	// The character in stage 1 can be handled whenever the output register
	// is empty or is being emptied in this cycle.
	assign slot_free = !out_valid_q || !out_stall;
	assign fire      = valid_s1 && slot_free;
	assign in_stall  = valid_s1 && !slot_free;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_accept || (valid_s1 && !fire);
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			code_s1  <= code_unit;
			start_s1 <= starts_string;
		end
	end

	// One character of the parse: classify, write a nibble, step counters, flag a result.
	always_comb begin
		logic [2:0] g;
		logic [4:0] hex;
		logic [3:0] pos;
		logic [4:0] count_inc;
		logic       skip;

		bytes_n     = bytes_q;
		group_n     = group_q;
		digits_n    = digits_q;
		decoding_n  = decoding_q;
		bad_n       = bad_q;
		finished_n  = finished_q;
		emit        = 1'b0;
		emit_status = gdt_pkg::STATUS_OK;
		skip        = 1'b0;
		hex         = gdt_pkg::hex_value(code_s1);
		pos         = 4'd0;
		count_inc   = 5'd0;

		if (start_s1) begin
			for (int i = 0; i < gdt_pkg::BYTE_COUNT; i++) begin
				bytes_n[i] = '0;
			end
			group_n    = 3'd0;
			digits_n   = 4'd0;
			decoding_n = 1'b1;
			bad_n      = 1'b0;
			finished_n = 1'b0;
		end

		g = (group_n > gdt_pkg::LAST_GROUP) ? gdt_pkg::LAST_GROUP : group_n;

		if (!finished_n) begin
			group_n = g;
			if (decoding_n) begin
				if (!hex[4]) begin
					pos       = gdt_pkg::group_first_byte(g) + {1'b0, digits_n[3:1]};
					if (!digits_n[0]) begin
						bytes_n[pos] = {hex[3:0], 4'h0};
					end else begin
						bytes_n[pos] = (bytes_n[pos] & gdt_pkg::HIGH_NIBBLE_MASK)
							| {4'h0, hex[3:0]};
					end
					count_inc = {1'b0, digits_n} + 5'd1;
					digits_n  = count_inc[3:0];
					if (count_inc >= gdt_pkg::group_digits(g)) begin
						decoding_n = 1'b0;
						if (g == gdt_pkg::LAST_GROUP) begin
							emit        = 1'b1;
							emit_status = bad_n ? gdt_pkg::STATUS_BAD_DIGIT
								: gdt_pkg::STATUS_OK;
						end
					end
				end else begin
					bad_n      = 1'b1;
					decoding_n = 1'b0;
					if (g == gdt_pkg::LAST_GROUP) begin
						emit        = 1'b1;
						emit_status = gdt_pkg::STATUS_BAD_DIGIT;
					end else begin
						skip = 1'b1;
					end
				end
			end else begin
				skip = 1'b1;
			end

			// Outside a digit run, wait for the hyphen that opens the next group; a NUL ends the string.
			if (skip) begin
				if (code_s1 == gdt_pkg::CHAR_HYPHEN) begin
					group_n    = g + 3'd1;
					digits_n   = 4'd0;
					decoding_n = 1'b1;
				end else if (code_s1 == gdt_pkg::CHAR_NUL) begin
					emit        = 1'b1;
					emit_status = gdt_pkg::STATUS_MISSING_SEP;
				end
			end

			if (emit) begin
				finished_n = 1'b1;
			end
		end

		for (int i = 0; i < 8; i++) begin
			first_n[63 - 8 * i -: 8]  = bytes_n[i];
			second_n[63 - 8 * i -: 8] = bytes_n[8 + i];
		end
		if (emit_status == gdt_pkg::STATUS_MISSING_SEP) begin
			first_n  = '0;
			second_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < gdt_pkg::BYTE_COUNT; i++) begin
				bytes_q[i] <= '0;
			end
			group_q    <= 3'd0;
			digits_q   <= 4'd0;
			decoding_q <= 1'b1;
			bad_q      <= 1'b0;
			finished_q <= 1'b1;
		end else if (fire) begin
			bytes_q    <= bytes_n;
			group_q    <= group_n;
			digits_q   <= digits_n;
			decoding_q <= decoding_n;
			bad_q      <= bad_n;
			finished_q <= finished_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			first_q  <= first_n;
			second_q <= second_n;
			status_q <= emit_status;
		end
	end

	assign out_valid        = out_valid_q;
	assign guid_first_half  = first_q;
	assign guid_second_half = second_q;
	assign status           = status_q;

endmodule

// ===== tb/tb_guid_text_to_bytes.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for guid_text_to_bytes: random GUID strings go in one character at a
// time, and a built-in model of the parse predicts each result. Depends on gdt_pkg.
module tb_guid_text_to_bytes;

	// The random part stops once this many characters have reached an open
	// string.
	localparam int ITEM_TARGET   = 750;
	// A result reaches the output register at the edge that consumes its last
	// character, so this wait after the last expected result is plenty.
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 300_000;

	typedef struct {
		logic [63:0]      first_half;
		logic [63:0]      second_half;
		gdt_pkg::status_t st;
	} guid_result_t;

	typedef enum {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_LONG} stall_mode_t;

	// Parse model and the queue of GUIDs it expects. Every character the
	// block accepts goes through note_request; every result the block hands
	// out goes through check_result against the oldest expected GUID.
	class guid_scoreboard;
		gdt_pkg::byte_t text_bytes [gdt_pkg::BYTE_COUNT];
		logic [2:0]     group_idx;
		logic [3:0]     digit_count;
		bit             decoding;
		bit             skipped_non_hex;
		bit             waiting_for_start;
		guid_result_t   expected_guids [$];
		int             errors;
		int             parsed;
		int             results;
		int             status_seen [3];

		function new();
			clear_parse();
			waiting_for_start = 1'b1;
			errors = 0;
			parsed = 0;
			results = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
		endfunction

		function void clear_parse();
			foreach (text_bytes[i]) text_bytes[i] = 8'h00;
			group_idx = 3'd0;
			digit_count = 4'd0;
			decoding = 1'b1;
			skipped_non_hex = 1'b0;
		endfunction

		// Groups hold 8, 4, 4, 4 and 12 digits; the inner groups start at
		// byte 4, 6 and 8, the last at byte 10.
		function int group_len(input logic [2:0] g);
			return (g == 3'd0) ? 8 : (g == gdt_pkg::LAST_GROUP) ? 12 : 4;
		endfunction

		function int group_base(input logic [2:0] g);
			return (g == 3'd0) ? 0 : 2 + 2 * int'(g);
		endfunction

		// Only the full 16-bit code unit counts: 0x0130 is not a digit.
		function bit decode_hex(input logic [15:0] c, output logic [3:0] v);
			v = 4'h0;
			if (c >= 16'h0030 && c <= 16'h0039) begin
				v = c[3:0];
				return 1'b1;
			end
			if ((c >= 16'h0041 && c <= 16'h0046) || (c >= 16'h0061 && c <= 16'h0066)) begin
				v = c[3:0] + 4'd9;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function void finish_string(input gdt_pkg::status_t st);
			guid_result_t r;
			r.first_half = '0;
			r.second_half = '0;
			r.st = st;
			// A missing hyphen discards whatever bytes were decoded.
			if (st != gdt_pkg::STATUS_MISSING_SEP) begin
				for (int i = 0; i < 8; i++) begin
					r.first_half = {r.first_half[55:0], text_bytes[i]};
					r.second_half = {r.second_half[55:0], text_bytes[i + 8]};
				end
			end
			expected_guids.push_back(r);
			waiting_for_start = 1'b1;
		endfunction

		function void note_request(input logic [15:0] c, input logic starts);
			logic [3:0] nibble;
			int         pos;
			if (starts) begin
				clear_parse();
				waiting_for_start = 1'b0;
			end
			if (waiting_for_start) return;
			parsed++;
			if (decoding) begin
				if (decode_hex(c, nibble)) begin
					pos = group_base(group_idx) + int'(digit_count[3:1]);
					if (!digit_count[0]) text_bytes[pos] = {nibble, 4'h0};
					else text_bytes[pos][3:0] = nibble;
					digit_count = digit_count + 4'd1;
					if (int'(digit_count) == group_len(group_idx)) begin
						decoding = 1'b0;
						if (group_idx == gdt_pkg::LAST_GROUP)
							finish_string(skipped_non_hex ? gdt_pkg::STATUS_BAD_DIGIT
								: gdt_pkg::STATUS_OK);
					end
					return;
				end
				// A non-hex character closes the group early; outside the last
				// group it is still looked at as a possible separator.
				skipped_non_hex = 1'b1;
				decoding = 1'b0;
				if (group_idx == gdt_pkg::LAST_GROUP) begin
					finish_string(gdt_pkg::STATUS_BAD_DIGIT);
					return;
				end
			end
			if (c == gdt_pkg::CHAR_HYPHEN) begin
				group_idx = group_idx + 3'd1;
				digit_count = 4'd0;
				decoding = 1'b1;
			end else if (c == gdt_pkg::CHAR_NUL) begin
				finish_string(gdt_pkg::STATUS_MISSING_SEP);
			end
		endfunction

		function void check_result(input logic [63:0] fh, input logic [63:0] sh,
				input logic [1:0] st);
			guid_result_t want;
			if (expected_guids.size() == 0) begin
				errors++;
				$display("%0t: unexpected result %h %h status %0d", $time, fh, sh, st);
				return;
			end
			want = expected_guids.pop_front();
			results++;
			status_seen[want.st]++;
			if (fh !== want.first_half) begin
				errors++;
				$display("%0t: guid_first_half expected %h, got %h", $time, want.first_half, fh);
			end
			if (sh !== want.second_half) begin
				errors++;
				$display("%0t: guid_second_half expected %h, got %h", $time, want.second_half, sh);
			end
			if (st !== 2'(want.st)) begin
				errors++;
				$display("%0t: status expected %0d, got %0d", $time, want.st, st);
			end
		endfunction

		function int pending();
			return expected_guids.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [15:0] code_unit = 16'h0000;
	logic        starts_string = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [63:0] guid_first_half;
	logic [63:0] guid_second_half;
	logic [1:0]  status;

	guid_scoreboard sb;
	int             cycle_count = 0;
	int             burst_left = 0;
	int             stall_tick = 0;
	stall_mode_t    stall_mode = STALL_NONE;
	bit             string_head = 1'b0;
	bit             drained_mid = 1'b0;

	guid_text_to_bytes uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.code_unit        (code_unit),
		.starts_string    (starts_string),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.guid_first_half  (guid_first_half),
		.guid_second_half (guid_second_half),
		.status           (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Give up if the run hangs, e.g. a result that never comes out.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timed out with %0d results outstanding", $time, sb.pending());
			$display("[guid_text_to_bytes] ERROR");
			$finish;
		end
	end

	// The receiver periodically picks at random between never stalling, a coin
	// flip per cycle, stalling most cycles, and long periodic stalls, so the
	// output register also gets held while characters keep arriving.
	always @(posedge clk) begin
		stall_tick++;
		if (stall_tick % 64 == 0) stall_mode = stall_mode_t'($urandom_range(0, 3));
		case (stall_mode)
			STALL_NONE:  out_stall <= 1'b0;
			STALL_COIN:  out_stall <= 1'($urandom_range(0, 1));
			STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
			default:     out_stall <= (stall_tick % 24) < 18;
		endcase
	end

	// Results are checked at the edge that takes them.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(guid_first_half, guid_second_half, status);
	end

	// Presents one character and holds it until the block takes it. The
	// sender runs in bursts and may idle between them. The model hears
	// about the request at the edge that accepts it.
	task automatic send_item(input logic [15:0] c, input logic starts);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		code_unit <= c;
		starts_string <= starts;
		do @(posedge clk); while (in_stall);
		sb.note_request(c, starts);
	endtask

	// The first character after string_head is set opens a new string.
	task automatic put_char(input logic [15:0] c);
		send_item(c, string_head);
		string_head = 1'b0;
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++) put_char({8'h00, s[i]});
	endtask

	// Stops sending and waits until every expected result has been taken.
	// The extra edge keeps the next raise of in_valid in a later time step.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	function automatic logic [15:0] hex_char();
		int unsigned v;
		v = $urandom_range(0, 15);
		if (v < 10) return 16'h0030 + 16'(v);
		return ($urandom_range(0, 1) ? 16'h0061 : 16'h0041) + 16'(v - 10);
	endfunction

	// Mostly non-hex characters: the neighbors of the digit ranges, characters
	// whose low byte looks like a digit, and anything else in the 16-bit range.
	function automatic logic [15:0] odd_char();
		logic [15:0] c;
		logic [15:0] digit;
		case ($urandom_range(0, 3))
			0: begin
				case ($urandom_range(0, 7))
					0:       c = 16'h002F;
					1:       c = 16'h003A;
					2:       c = 16'h0040;
					3:       c = 16'h0047;
					4:       c = 16'h0060;
					5:       c = 16'h0067;
					6:       c = 16'hFFFF;
					default: c = 16'h0020;
				endcase
			end
			1: begin
				digit = hex_char();
				c = {8'($urandom_range(1, 255)), digit[7:0]};
			end
			default: c = 16'($urandom_range(1, 65535));
		endcase
		return c;
	endfunction

	function automatic logic [15:0] any_char();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick < 4) return hex_char();
		if (pick == 4) return gdt_pkg::CHAR_HYPHEN;
		if (pick == 5) return gdt_pkg::CHAR_NUL;
		return odd_char();
	endfunction

	// Mostly well-formed GUID text with random digits in either case. Now and
	// then a group stops early (on junk, a hyphen or a NUL), carries extra
	// characters before its hyphen, ends on a NUL instead of a hyphen, or the
	// string is simply abandoned so that the next start cuts it off. About
	// one string in six is a few random characters only.
	task automatic send_random_string();
		int          len;
		int          cut;
		logic [15:0] stop;
		string_head = 1'b1;
		if ($urandom_range(0, 5) == 0) begin
			len = $urandom_range(1, 6);
			repeat (len) put_char(any_char());
			return;
		end
		for (int g = 0; g < gdt_pkg::GROUP_COUNT; g++) begin
			len = (g == 0) ? 8 : (g == gdt_pkg::LAST_GROUP) ? 12 : 4;
			if ($urandom_range(0, 9) == 0) begin
				cut = $urandom_range(0, len - 1);
				repeat (cut) put_char(hex_char());
				case ($urandom_range(0, 4))
					0:       stop = gdt_pkg::CHAR_HYPHEN;
					1:       stop = gdt_pkg::CHAR_NUL;
					default: stop = odd_char();
				endcase
				put_char(stop);
				if (g == gdt_pkg::LAST_GROUP || stop == gdt_pkg::CHAR_NUL) return;
				if (stop == gdt_pkg::CHAR_HYPHEN) continue;
			end else begin
				repeat (len) put_char(hex_char());
				if (g == gdt_pkg::LAST_GROUP) return;
			end
			if ($urandom_range(0, 7) == 0)
				repeat ($urandom_range(1, 3))
					put_char($urandom_range(0, 1) ? hex_char() : odd_char());
			if ($urandom_range(0, 29) == 0) begin
				put_char(gdt_pkg::CHAR_NUL);
				return;
			end
			if ($urandom_range(0, 39) == 0) return;
			put_char(gdt_pkg::CHAR_HYPHEN);
		end
	endtask

	initial begin
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A character before any string start is dropped.
		string_head = 1'b0;
		put_text("Z");
		// A string cut off by a new start, then a clean GUID using every
		// decimal digit and hex letters in both cases, a skipped 0xFFFF after a full
		// group, and a trailing character that arrives after the result.
		string_head = 1'b1;
		put_text("9a");
		string_head = 1'b1;
		put_text("0123abcd");
		put_char(16'hFFFF);
		put_text("-EF45-6789-aAfF-0123456789fF");
		put_text("7");
		// NUL before a hyphen: missing-hyphen status, both halves zero.
		string_head = 1'b1;
		put_text("Ab");
		put_char(gdt_pkg::CHAR_NUL);
		// Every group holds a single digit, stopped by the characters next to the
		// hex ranges; the last group ends on a character whose low byte is '0'.
		string_head = 1'b1;
		put_text("f/-e`-dG-cg-b");
		put_char(16'h0130);
		drain_results();

		while (sb.parsed < ITEM_TARGET) begin
			send_random_string();
			// Stray characters after a string, usually dropped by the block.
			if ($urandom_range(0, 3) == 0) begin
				string_head = 1'b0;
				repeat ($urandom_range(1, 3)) put_char(any_char());
			end
			if (!drained_mid && sb.parsed >= ITEM_TARGET / 2) begin
				drain_results();
				drained_mid = 1'b1;
			end
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Fed %0d characters into open strings and checked %0d GUID results,",
			sb.parsed, sb.results);
		$display("of which %0d clean, %0d with non-hex digits, %0d with a missing hyphen.",
			sb.status_seen[gdt_pkg::STATUS_OK], sb.status_seen[gdt_pkg::STATUS_BAD_DIGIT],
			sb.status_seen[gdt_pkg::STATUS_MISSING_SEP]);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("[guid_text_to_bytes] OK");
		end else begin
			$display("[guid_text_to_bytes] ERROR");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/gdt_pkg.sv
hw/rtl/guid_text_to_bytes.sv
tb/tb_guid_text_to_bytes.sv
